>>> rtl/core/wvpl_pkg.sv
// shared types and constants for the wireframe vertex projector
`timescale 1ns / 1ps
`default_nettype none

package wvpl_pkg;

  // default arithmetic precision and screen width
  localparam int unsigned FracBitsDef   = 16;
  localparam int unsigned ScreenBitsDef = 16;

  // command codes
  localparam logic CmdLoad   = 1'b0;
  localparam logic CmdVertex = 1'b1;

  // configuration register indexes
  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegLeft   = 2'd2;
  localparam logic [1:0] RegTop    = 2'd3;

  // configuration reset values
  localparam logic [13:0] WidthRst  = 14'd640;
  localparam logic [13:0] HeightRst = 14'd480;
  localparam logic [12:0] LeftRst   = 13'd0;
  localparam logic [12:0] TopRst    = 13'd0;

  typedef struct packed {
    logic [13:0] width;
    logic [13:0] height;
    logic [12:0] left;
    logic [12:0] top;
  } viewport_t;

  // one queued input transaction
  typedef struct packed {
    logic               is_vertex;
    logic [3:0]         coeff_index;
    logic signed [31:0] coeff_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               last;
  } item_t;

  // projected vertex handed to the pairing stage
  typedef struct packed {
    logic               kept;
    logic               nonneg;
    logic               last;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
  } vtx_t;

  // one line segment
  typedef struct packed {
    logic signed [15:0] x0;
    logic signed [15:0] y0;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic               last;
  } seg_t;

endpackage

`default_nettype wire

>>> rtl/core/wvpl_front.sv
// front end: input transaction queue and command classification
`timescale 1ns / 1ps
`default_nettype none

module wvpl_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                command_i,
  input  wire logic [3:0]          coeff_index_i,
  input  wire logic signed [31:0]  coeff_value_i,
  input  wire logic signed [31:0]  pos_x_i,
  input  wire logic signed [31:0]  pos_y_i,
  input  wire logic signed [31:0]  pos_z_i,
  input  wire logic                last_in_polygon_i,
  output logic                     item_valid_o,
  input  wire logic                item_ready_i,
  output wvpl_pkg::item_t          item_o
);

  wvpl_pkg::item_t mem_q [2];
  wvpl_pkg::item_t new_item;
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q;
  logic            push, pop;

  always_comb begin
    new_item.is_vertex   = (command_i == wvpl_pkg::CmdVertex);
    new_item.coeff_index = coeff_index_i;
    new_item.coeff_value = coeff_value_i;
    new_item.pos_x       = pos_x_i;
    new_item.pos_y       = pos_y_i;
    new_item.pos_z       = pos_z_i;
    new_item.last        = last_in_polygon_i;
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/wvpl_xform.sv
// back end: matrix store, transform, depth test, divide and viewport map
`timescale 1ns / 1ps
`default_nettype none

module wvpl_xform #(
  parameter int unsigned FRAC_BITS   = wvpl_pkg::FracBitsDef,
  parameter int unsigned SCREEN_BITS = wvpl_pkg::ScreenBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                item_valid_i,
  output logic                     item_ready_o,
  input  wire wvpl_pkg::item_t     item_i,
  input  wire wvpl_pkg::viewport_t viewport_i,
  output logic                     vtx_valid_o,
  input  wire logic                vtx_ready_i,
  output wvpl_pkg::vtx_t           vtx_o
);

  localparam int unsigned TW  = 66 - FRAC_BITS;   // transformed coordinate
  localparam int unsigned QB  = 25 + FRAC_BITS;   // quotient bits
  localparam int unsigned NXW = QB + 2;           // signed ndc
  localparam int unsigned PW  = NXW + 15;         // ndc times extent
  localparam int unsigned XW  = PW + 1;           // doubled screen coordinate
  localparam int unsigned PIX = (SCREEN_BITS < 16) ? SCREEN_BITS : 16;
  localparam int unsigned CW  = $clog2(QB + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_DRAIN = 4'd2;
  localparam logic [3:0] S_TEST  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_VPMUL = 4'd5;
  localparam logic [3:0] S_VPADD = 4'd6;
  localparam logic [3:0] S_PIX   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]               state_q;
  logic signed [31:0]       matrix_q [16];
  logic signed [31:0]       pos_q [3];
  logic                     last_q;
  logic [1:0]               row_q, col_q, prod_col_q;
  logic                     prod_v_q;
  logic signed [63:0]       prod_q, prod_d, prod_sh;
  logic signed [TW-1:0]     acc_q [4];
  logic [TW-1:0]            ud_q, rx_q, ry_q;
  logic [QB-1:0]            qx_q, qy_q;
  logic                     ovx_q, ovy_q, negx_q, negy_q;
  logic [CW-1:0]            div_cnt_q;
  logic signed [PW-1:0]     px_q, py_q;
  logic signed [XW-1:0]     x2_q, y2_q;
  wvpl_pkg::vtx_t           vtx_q;

  // combinational helpers
  logic signed [TW-1:0]     tx, ty, tz, tw;
  logic                     kept;
  logic [TW-1:0]            unx, uny, ud;
  logic [TW:0]              rx_sh, ry_sh, rx_n, ry_n;
  logic                     gex, gey;
  logic [NXW-2:0]           magx, magy;
  logic signed [NXW-1:0]    nx, ny;
  logic signed [14:0]       ws, hs;
  logic signed [XW-1:0]     offx, offy;

  function automatic logic signed [15:0] to_pixel(input logic signed [XW-1:0] v2);
    logic [XW-1:0] mag;
    logic [XW-1:0] ip;
    logic [XW-1:0] lim;
    logic [15:0]   res;
    mag = v2[XW-1] ? (~v2 + XW'(1)) : v2;
    ip  = mag >> (FRAC_BITS + 1);
    lim = XW'(1) << (PIX - 1);
    if (!v2[XW-1]) begin
      res = (ip >= lim) ? 16'(lim - XW'(1)) : 16'(ip);
    end else begin
      res = (ip >= lim) ? -16'(lim) : -16'(ip);
    end
    return res;
  endfunction

  assign item_ready_o = (state_q == S_IDLE);
  assign vtx_valid_o  = (state_q == S_OUT);
  assign vtx_o        = vtx_q;

  // single shared multiplier for the 12 matrix products
  assign prod_d  = pos_q[row_q] * matrix_q[{row_q, col_q}];
  assign prod_sh = prod_q >>> FRAC_BITS;

  assign tx = acc_q[0];
  assign ty = acc_q[1];
  assign tz = acc_q[2];
  assign tw = acc_q[3];

  always_comb begin
    if (tw > 0)      kept = (tz >= 0) && (tz <= tw);
    else if (tw < 0) kept = (tz <= 0) && (tz >= tw);
    else             kept = 1'b0;
  end

  assign unx = tx[TW-1] ? (~tx + TW'(1)) : tx;
  assign uny = ty[TW-1] ? (~ty + TW'(1)) : ty;
  assign ud  = tw[TW-1] ? (~tw + TW'(1)) : tw;

  // restoring divider step, one quotient bit per cycle for both axes
  assign rx_sh = {rx_q, qx_q[QB-1]};
  assign ry_sh = {ry_q, qy_q[QB-1]};
  assign gex   = (rx_sh >= {1'b0, ud_q});
  assign gey   = (ry_sh >= {1'b0, ud_q});
  assign rx_n  = gex ? (rx_sh - {1'b0, ud_q}) : rx_sh;
  assign ry_n  = gey ? (ry_sh - {1'b0, ud_q}) : ry_sh;

  // ndc saturates at 2^25
  assign magx = ovx_q ? ((NXW-1)'(1) << QB) : {1'b0, qx_q};
  assign magy = ovy_q ? ((NXW-1)'(1) << QB) : {1'b0, qy_q};
  assign nx   = negx_q ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
  assign ny   = negy_q ? -$signed({1'b0, magy}) : $signed({1'b0, magy});

  assign ws   = $signed({1'b0, viewport_i.width});
  assign hs   = $signed({1'b0, viewport_i.height});
  assign offx = ((XW'(viewport_i.left) << 1) + XW'(viewport_i.width)) << FRAC_BITS;
  assign offy = ((XW'(viewport_i.top) << 1) + XW'(viewport_i.height)) << FRAC_BITS;

  // matrix store, identity after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        matrix_q[i] <= ((i % 5) == 0) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
      end
    end else if (item_valid_i && item_ready_o && !item_i.is_vertex) begin
      matrix_q[item_i.coeff_index] <= item_i.coeff_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      row_q     <= 2'd0;
      col_q     <= 2'd0;
      prod_v_q  <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      prod_v_q <= (state_q == S_MUL);
      unique case (state_q)
        S_IDLE: begin
          if (item_valid_i && item_i.is_vertex) begin
            row_q   <= 2'd0;
            col_q   <= 2'd0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          if (row_q == 2'd2) begin
            row_q <= 2'd0;
            col_q <= col_q + 2'd1;
            if (col_q == 2'd3) state_q <= S_DRAIN;
          end else begin
            row_q <= row_q + 2'd1;
          end
        end
        S_DRAIN: state_q <= S_TEST;
        S_TEST: begin
          div_cnt_q <= CW'(QB);
          state_q   <= kept ? S_DIV : S_OUT;
        end
        S_DIV: begin
          div_cnt_q <= div_cnt_q - CW'(1);
          if (div_cnt_q == CW'(1)) state_q <= S_VPMUL;
        end
        S_VPMUL: state_q <= S_VPADD;
        S_VPADD: state_q <= S_PIX;
        S_PIX:   state_q <= S_OUT;
        S_OUT: begin
          if (vtx_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      pos_q[0] <= item_i.pos_x;
      pos_q[1] <= item_i.pos_y;
      pos_q[2] <= item_i.pos_z;
      last_q   <= item_i.last;
      for (int c = 0; c < 4; c++) begin
        acc_q[c] <= {{(TW-32){matrix_q[12+c][31]}}, matrix_q[12+c]};
      end
    end else if (prod_v_q) begin
      acc_q[prod_col_q] <= acc_q[prod_col_q] + $signed(prod_sh[TW-1:0]);
    end
    prod_q     <= prod_d;
    prod_col_q <= col_q;

    if (state_q == S_TEST) begin
      ud_q   <= ud;
      negx_q <= tx[TW-1] ^ tw[TW-1];
      negy_q <= ty[TW-1] ^ tw[TW-1];
      ovx_q  <= ({25'd0, unx} >= {ud, 25'd0});
      ovy_q  <= ({25'd0, uny} >= {ud, 25'd0});
      rx_q   <= TW'(unx >> 25);
      ry_q   <= TW'(uny >> 25);
      qx_q   <= {unx[24:0], {FRAC_BITS{1'b0}}};
      qy_q   <= {uny[24:0], {FRAC_BITS{1'b0}}};
      vtx_q.kept   <= kept;
      vtx_q.nonneg <= 1'b0;
      vtx_q.last   <= last_q;
      vtx_q.sx     <= 16'sd0;
      vtx_q.sy     <= 16'sd0;
    end else if (state_q == S_DIV) begin
      rx_q <= rx_n[TW-1:0];
      ry_q <= ry_n[TW-1:0];
      qx_q <= {qx_q[QB-2:0], gex};
      qy_q <= {qy_q[QB-2:0], gey};
    end

    if (state_q == S_VPMUL) begin
      px_q <= nx * ws;
      py_q <= ny * hs;
    end
    if (state_q == S_VPADD) begin
      x2_q <= XW'(px_q) + offx;
      y2_q <= offy - XW'(py_q);
    end
    if (state_q == S_PIX) begin
      vtx_q.nonneg <= !x2_q[XW-1];
      vtx_q.sx     <= to_pixel(x2_q);
      vtx_q.sy     <= to_pixel(y2_q);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/wvpl_pair.sv
// segment pairing, polygon closing and output slots
`timescale 1ns / 1ps
`default_nettype none

module wvpl_pair (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            vtx_valid_i,
  output logic                 vtx_ready_o,
  input  wire wvpl_pkg::vtx_t  vtx_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output wvpl_pkg::seg_t       seg_o
);

  wvpl_pkg::seg_t     slot_q [2];
  logic [1:0]         slot_v_q;
  logic signed [15:0] prev_x_q, prev_y_q, first_x_q, first_y_q;
  logic               prev_nn_q, first_in_q, at_start_q;

  // next polygon state and segments for the incoming vertex
  logic signed [15:0] fx, fy, px, py;
  logic               fin, pnn, seg_a, seg_b;
  wvpl_pkg::seg_t     a, b;
  logic               take, pop;

  assign vtx_ready_o = !slot_v_q[0];
  assign out_valid_o = slot_v_q[0];
  assign seg_o       = slot_q[0];
  assign take        = vtx_valid_i && vtx_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    fx  = at_start_q ? vtx_i.sx   : first_x_q;
    fy  = at_start_q ? vtx_i.sy   : first_y_q;
    fin = at_start_q ? vtx_i.kept : first_in_q;
    seg_a = vtx_i.kept && prev_nn_q;
    a.x0 = prev_x_q;
    a.y0 = prev_y_q;
    a.x1 = vtx_i.sx;
    a.y1 = vtx_i.sy;
    px  = vtx_i.kept ? vtx_i.sx     : prev_x_q;
    py  = vtx_i.kept ? vtx_i.sy     : prev_y_q;
    pnn = vtx_i.kept ? vtx_i.nonneg : prev_nn_q;
    seg_b = vtx_i.last && fin && pnn;
    b.x0 = px;
    b.y0 = py;
    b.x1 = fx;
    b.y1 = fy;
    b.last = 1'b1;
    a.last = !seg_b;
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      slot_q[0] <= seg_a ? a : b;
      slot_q[1] <= b;
    end else if (pop) begin
      slot_q[0] <= slot_q[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_v_q   <= 2'b00;
      prev_x_q   <= -16'sd1;
      prev_y_q   <= 16'sd0;
      prev_nn_q  <= 1'b0;
      first_x_q  <= 16'sd0;
      first_y_q  <= 16'sd0;
      first_in_q <= 1'b0;
      at_start_q <= 1'b1;
    end else if (take) begin
      slot_v_q   <= {seg_a && seg_b, seg_a || seg_b};
      first_x_q  <= fx;
      first_y_q  <= fy;
      first_in_q <= fin;
      if (vtx_i.last) begin
        prev_x_q   <= -16'sd1;
        prev_y_q   <= 16'sd0;
        prev_nn_q  <= 1'b0;
        at_start_q <= 1'b1;
      end else begin
        prev_x_q   <= px;
        prev_y_q   <= py;
        prev_nn_q  <= pnn;
        at_start_q <= 1'b0;
      end
    end else if (pop) begin
      slot_v_q <= {1'b0, slot_v_q[1]};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/wireframe_vertex_project_to_lines_top.sv
// top level of the wireframe vertex projector
`timescale 1ns / 1ps
`default_nettype none

// wireframe vertex projector: a command 0 transaction loads one Q16.16 coefficient of the
// 4x4 transform (identity after reset); a command 1 transaction transforms a vertex as a
// row vector, keeps it when w is nonzero and 0 <= z/w <= 1, maps it to the viewport and
// emits up to two line segments (to the previous kept point, and the polygon close after
// last_in_polygon). a two entry input queue decouples the input from the back end. the
// back end takes a load while idle; a vertex runs through the 12 products on one shared
// 32x32 multiplier, the depth test and, when kept, the bit-per-cycle restoring divider
// for x/w and y/w and the viewport map. the next transaction is taken only back in idle,
// and a vertex is held while the pairing stage still holds segments that the output has
// not taken. the viewport registers are written through the cfg port, which is always
// ready; the user must write them only while the block is idle; it does not enforce that

module wireframe_vertex_project_to_lines_top #(
  parameter int unsigned FRAC_BITS   = wvpl_pkg::FracBitsDef,
  parameter int unsigned SCREEN_BITS = wvpl_pkg::ScreenBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [13:0]        cfg_data_i,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               command_i,
  input  wire logic [3:0]         coeff_index_i,
  input  wire logic signed [31:0] coeff_value_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic               last_in_polygon_i,
  // segment output channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      line_start_x_o,
  output logic signed [15:0]      line_start_y_o,
  output logic signed [15:0]      line_end_x_o,
  output logic signed [15:0]      line_end_y_o,
  output logic                    last_segment_o
);

  wvpl_pkg::viewport_t viewport_q;
  wvpl_pkg::item_t     item;
  logic                item_valid, item_ready;
  wvpl_pkg::vtx_t      vtx;
  logic                vtx_valid, vtx_ready;
  wvpl_pkg::seg_t      seg;

  // viewport registers, writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      viewport_q.width  <= wvpl_pkg::WidthRst;
      viewport_q.height <= wvpl_pkg::HeightRst;
      viewport_q.left   <= wvpl_pkg::LeftRst;
      viewport_q.top    <= wvpl_pkg::TopRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        wvpl_pkg::RegWidth:  viewport_q.width  <= cfg_data_i;
        wvpl_pkg::RegHeight: viewport_q.height <= cfg_data_i;
        wvpl_pkg::RegLeft:   viewport_q.left   <= cfg_data_i[12:0];
        wvpl_pkg::RegTop:    viewport_q.top    <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // front: input queue and command classification
  wvpl_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .coeff_index_i     (coeff_index_i),
    .coeff_value_i     (coeff_value_i),
    .pos_x_i           (pos_x_i),
    .pos_y_i           (pos_y_i),
    .pos_z_i           (pos_z_i),
    .last_in_polygon_i (last_in_polygon_i),
    .item_valid_o      (item_valid),
    .item_ready_i      (item_ready),
    .item_o            (item)
  );

  // back: matrix, transform, divide and viewport mapping
  wvpl_xform #(
    .FRAC_BITS   (FRAC_BITS),
    .SCREEN_BITS (SCREEN_BITS)
  ) u_xform (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .viewport_i   (viewport_q),
    .vtx_valid_o  (vtx_valid),
    .vtx_ready_i  (vtx_ready),
    .vtx_o        (vtx)
  );

  // pairing of kept points into segments, polygon close
  wvpl_pair u_pair (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vtx_valid_i (vtx_valid),
    .vtx_ready_o (vtx_ready),
    .vtx_i       (vtx),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .seg_o       (seg)
  );

  assign line_start_x_o = seg.x0;
  assign line_start_y_o = seg.y0;
  assign line_end_x_o   = seg.x1;
  assign line_end_y_o   = seg.y1;
  assign last_segment_o = seg.last;

`ifndef NO_ASSERTIONS
  // a full input queue always presents a transaction to the back end
  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> item_valid)
    else $error("input queue full but empty head");

  // a projected vertex waiting on the pairing stage holds
  a_vtx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtx_valid && !vtx_ready |=> vtx_valid && $stable(vtx))
    else $error("projected vertex dropped or changed while stalled");

  // the second segment of a pair follows right after the first
  a_seg_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_segment_o |=> out_valid_o)
    else $error("missing second segment");
`endif

endmodule

`default_nettype wire

>>> tb/tb_wireframe_vertex_project_to_lines_top.sv
// testbench for the wireframe vertex projector: directed and random vertex streams, checked
// against a cycle-free predictor of the projection and segment pairing
`timescale 1ns / 1ps

module tb_wireframe_vertex_project_to_lines_top;
  import wvpl_pkg::*;

  localparam int FRAC = 16;
  localparam longint ONE = 64'sd1 << FRAC;
  localparam int CYCLE_LIMIT = 1000000;
  // a load or a vertex without segments may still be in flight, up to three of them
  localparam int SETTLE_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = RegWidth;
  logic [13:0] cfg_data = '0;

  logic in_valid = 1'b0;
  logic in_ready;
  item_t in_item = '0;

  logic out_valid;
  logic out_ready = 1'b0;
  seg_t out_seg;

  wireframe_vertex_project_to_lines_top dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .command_i         (in_item.is_vertex),
    .coeff_index_i     (in_item.coeff_index),
    .coeff_value_i     (in_item.coeff_value),
    .pos_x_i           (in_item.pos_x),
    .pos_y_i           (in_item.pos_y),
    .pos_z_i           (in_item.pos_z),
    .last_in_polygon_i (in_item.last),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .line_start_x_o    (out_seg.x0),
    .line_start_y_o    (out_seg.y0),
    .line_end_x_o      (out_seg.x1),
    .line_end_y_o      (out_seg.y1),
    .last_segment_o    (out_seg.last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // pending vertex and load transactions, and segments still to come
  item_t pending_items[$];
  seg_t expected_segs[$];
  int errors = 0;
  int cycles = 0;
  bit in_fired = 1'b0;

  // shadow of the block state
  longint matrix[16];
  longint prev_x, prev_y, first_x, first_y;
  bit prev_nonneg, first_kept, poly_start;
  viewport_t vp;

  // signed division to ndc with truncated magnitude, saturated at 2^25
  function automatic longint ndc_div(longint n, longint d);
    longint unsigned un, ud, qi, r, mag, frac;
    bit neg;
    neg = (n < 0) != (d < 0);
    un = (n < 0) ? longint'(-n) : n;
    ud = (d < 0) ? longint'(-d) : d;
    qi = un / ud;
    if (qi >= (64'd1 << 25)) begin
      mag = 64'd1 << (25 + FRAC);
    end else begin
      r = un % ud;
      frac = 0;
      // one fraction bit at a time keeps the remainder inside 64 bits
      for (int i = 0; i < FRAC; i++) begin
        r = r << 1;
        frac = frac << 1;
        if (r >= ud) begin
          r = r - ud;
          frac = frac | 64'd1;
        end
      end
      mag = (qi << FRAC) | frac;
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // doubled screen coordinate to saturated integer pixel, truncated toward zero
  function automatic longint to_screen(longint twice);
    longint unsigned mag;
    longint v;
    mag = (twice < 0) ? longint'(-twice) : twice;
    v = longint'(mag >> (FRAC + 1));
    if (twice < 0) v = -v;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  task automatic reset_shadow();
    for (int i = 0; i < 16; i++) matrix[i] = (i % 5 == 0) ? ONE : 0;
    prev_x = -1; prev_y = 0; prev_nonneg = 0;
    first_x = 0; first_y = 0; first_kept = 0; poly_start = 1;
    vp.width = WidthRst; vp.height = HeightRst; vp.left = LeftRst; vp.top = TopRst;
  endtask

  function automatic seg_t make_seg(longint x0, longint y0, longint x1, longint y1);
    seg_t s;
    s.x0 = x0[15:0]; s.y0 = y0[15:0]; s.x1 = x1[15:0]; s.y1 = y1[15:0]; s.last = 1'b0;
    return s;
  endfunction

  // works out the segments one accepted transaction causes
  task automatic project_item(input item_t it);
    longint p[3];
    longint t[4];
    longint sx, sy, nx, ny, x2, y2, w, h;
    bit kept, nonneg;
    seg_t segs[$];
    sx = 0; sy = 0; kept = 0; nonneg = 0;
    if (it.is_vertex == CmdLoad) begin
      matrix[it.coeff_index] = longint'(it.coeff_value);
      return;
    end
    p[0] = it.pos_x; p[1] = it.pos_y; p[2] = it.pos_z;
    for (int c = 0; c < 4; c++) begin
      t[c] = matrix[12 + c];
      for (int r = 0; r < 3; r++) t[c] += (p[r] * matrix[r * 4 + c]) >>> FRAC;
    end
    if (t[3] > 0) kept = t[2] >= 0 && t[2] <= t[3];
    else if (t[3] < 0) kept = t[2] <= 0 && t[2] >= t[3];
    if (kept) begin
      w = vp.width; h = vp.height;
      nx = ndc_div(t[0], t[3]);
      ny = ndc_div(t[1], t[3]);
      x2 = nx * w + ((2 * longint'(vp.left) + w) <<< FRAC);
      y2 = -ny * h + ((2 * longint'(vp.top) + h) <<< FRAC);
      nonneg = x2 >= 0;
      sx = to_screen(x2);
      sy = to_screen(y2);
    end
    if (poly_start) begin
      first_x = sx; first_y = sy; first_kept = kept; poly_start = 0;
    end
    if (kept) begin
      if (prev_nonneg) segs.push_back(make_seg(prev_x, prev_y, sx, sy));
      prev_x = sx; prev_y = sy; prev_nonneg = nonneg;
    end
    if (it.last) begin
      // polygon close back onto its first vertex
      if (first_kept && prev_nonneg) segs.push_back(make_seg(prev_x, prev_y, first_x, first_y));
      prev_x = -1; prev_y = 0; prev_nonneg = 0; poly_start = 1;
    end
    if (segs.size() > 0) segs[segs.size() - 1].last = 1'b1;
    foreach (segs[i]) expected_segs.push_back(segs[i]);
  endtask

  task automatic push_load(input int idx, input logic [31:0] val, input bit last);
    item_t it;
    it = '0;
    it.is_vertex = CmdLoad;
    it.coeff_index = idx[3:0];
    it.coeff_value = val;
    it.pos_x = $urandom; it.pos_y = $urandom; it.pos_z = $urandom;
    it.last = last;
    pending_items.push_back(it);
  endtask

  task automatic push_vertex(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                             input bit last);
    item_t it;
    it = '0;
    it.is_vertex = CmdVertex;
    it.coeff_index = 4'($urandom);
    it.coeff_value = $urandom;
    it.pos_x = x; it.pos_y = y; it.pos_z = z;
    it.last = last;
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] span(int range);
    return $urandom_range(0, 2 * range) - range;
  endfunction

  // loads a perspective-like matrix whose depth test passes for a good share of vertices
  task automatic load_random_matrix();
    int sgn;
    sgn = ($urandom_range(0, 3) == 0) ? -1 : 1;
    for (int r = 0; r < 4; r++) begin
      push_load(r * 4 + 0, span(3 * 65536), 0);
      push_load(r * 4 + 1, span(3 * 65536), 0);
    end
    push_load(2, 0, 0); push_load(6, 0, 0); push_load(14, 0, 0);
    push_load(10, sgn * 65536, 0);
    push_load(3, ($urandom_range(0, 1)) ? span(8192) : 0, 0);
    push_load(7, ($urandom_range(0, 1)) ? span(8192) : 0, 0);
    push_load(11, 0, 0);
    push_load(15, sgn * int'($urandom_range(32768, 131072)), 0);
  endtask

  // polygons of random content, with a little noise mixed in
  task automatic random_items(input int count);
    int made, len, rng;
    made = 0;
    while (made < count) begin
      case ($urandom_range(0, 19))
        0: begin
          push_load($urandom_range(0, 15), $urandom, 1'($urandom_range(0, 1)));
          made++;
        end
        1: begin
          push_vertex($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
          made++;
        end
        2: begin
          load_random_matrix();
          made += 16;
        end
        default: begin
          len = $urandom_range(1, 6);
          rng = ($urandom_range(0, 4) == 0) ? 32'h7fff_ffff : 4 * 65536;
          for (int i = 0; i < len; i++) begin
            push_vertex(span(rng), span(rng),
                        ($urandom_range(0, 9) == 0) ? span(2 * 65536)
                                                    : $urandom_range(0, 65536),
                        i == len - 1);
          end
          made += len;
        end
      endcase
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [13:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegWidth:  vp.width = data;
      RegHeight: vp.height = data;
      RegLeft:   vp.left = data[12:0];
      RegTop:    vp.top = data[12:0];
      default:   ;
    endcase
  endtask

  task automatic set_viewport(input logic [13:0] w, input logic [13:0] h,
                              input logic [13:0] l, input logic [13:0] t);
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    write_reg(RegLeft, l);
    write_reg(RegTop, t);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // all sent, all segments in, and the back end given time to finish silent work
  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_segs.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fired)) begin
      if (gap_left > 0 || pending_items.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        in_item <= pending_items.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // receiver: random stalls whose density is redrawn during the run, sometimes none at all
  int stall_pct = 0;
  always @(negedge clk) begin
    if (cycles % 300 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 30;
        2: stall_pct = 70;
        default: stall_pct = 95;
      endcase
    end
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // input accept and segment check
  always @(posedge clk) begin
    seg_t want;
    cycles++;
    in_fired = rst_n && in_valid && in_ready;
    if (in_fired) project_item(in_item);
    if (rst_n && out_valid && out_ready) begin
      if (expected_segs.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected segment %0d,%0d -> %0d,%0d last %0b",
                                   out_seg.x0, out_seg.y0, out_seg.x1, out_seg.y1, out_seg.last);
      end else begin
        want = expected_segs.pop_front();
        if (want !== out_seg) begin
          errors++;
          if (errors <= 10)
            $display("segment mismatch: expected %0d,%0d -> %0d,%0d last %0b, got %0d,%0d -> %0d,%0d last %0b",
                     want.x0, want.y0, want.x1, want.y1, want.last,
                     out_seg.x0, out_seg.y0, out_seg.x1, out_seg.y1, out_seg.last);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    reset_shadow();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: single kept vertex closes onto itself
    push_vertex(0, 0, 0, 1);
    // depth edges, a rejected middle vertex and a close
    push_vertex(65536, 65536, 65536, 0);
    push_vertex(-65536, -65536, 32768, 0);
    push_vertex(0, 0, 70000, 0);
    push_vertex(32768, 0, 0, 1);
    // rejected first vertex: no close
    push_vertex(0, 0, -1, 0);
    push_vertex(0, 0, 0, 0);
    push_vertex(1, 1, 1, 1);
    // saturation and negative screen x on the previous point
    push_vertex(32'h7fff_ffff, 32'h8000_0000, 0, 0);
    push_vertex(32'h8000_0000, 32'h7fff_ffff, 0, 0);
    push_vertex(0, 0, 0, 1);
    // zero w, last flag on a load is ignored
    push_load(15, 0, 1);
    push_vertex(0, 0, 0, 1);
    // negative w
    push_load(15, -65536, 0);
    push_vertex(0, 0, -32768, 0);
    push_vertex(65536, 0, 0, 1);
    // extreme coefficients
    push_load(0, 32'h8000_0000, 0);
    push_load(5, 32'h7fff_ffff, 0);
    push_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1);
    push_load(0, 65536, 0);
    push_load(5, 65536, 0);
    push_load(15, 65536, 0);
    wait_idle();

    random_items(300);
    wait_idle();
    set_viewport(14'd8192, 14'd8192, 14'd8191, 14'd8191);
    random_items(300);
    wait_idle();
    set_viewport(14'd1, 14'd1, 14'd0, 14'd0);
    random_items(300);
    wait_idle();
    // degenerate registers: zero size and all bits set
    set_viewport(14'd0, 14'h3fff, 14'h3fff, 14'd0);
    random_items(300);
    wait_idle();
    set_viewport(14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)),
                 14'($urandom_range(0, 8191)), 14'($urandom_range(0, 8191)));
    random_items(400);
    wait_idle();
    set_viewport(14'd640, 14'd480, 14'd0, 14'd0);
    random_items(400);
    wait_idle();

    if (errors == 0 && expected_segs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/wvpl_pkg.sv
rtl/core/wvpl_front.sv
rtl/core/wvpl_xform.sv
rtl/core/wvpl_pair.sv
rtl/core/wireframe_vertex_project_to_lines_top.sv
tb/tb_wireframe_vertex_project_to_lines_top.sv
